@@ sv/bvt_pkg.sv @@
// ----------------------------------------------------------------------------
// bvt_pkg
// Shared widths, operation codes and controller/datapath bundles for the
// block version table.
// ----------------------------------------------------------------------------
package bvt_pkg;

    localparam int KIND_W         = 3;
    localparam int BLOCK_W        = 10;
    localparam int DATA_W         = 32;
    localparam int NUM_BLOCKS_DEF = 1024;

    localparam logic [DATA_W-1:0] NO_VERSION = '1;

    // Operation codes carried in the kind field
    typedef enum logic [KIND_W-1:0] {
        OP_SET_CNT     = 3'd0,
        OP_ADD_CNT     = 3'd1,
        OP_RD_CNT      = 3'd2,
        OP_RD_ENTRY    = 3'd3,
        OP_WR_ENTRY    = 3'd4,
        OP_FIND_OLDEST = 3'd5,
        OP_FIND_THR    = 3'd6
    } bvt_op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;       // capture the input beat
        logic exec;        // carry out a single-step operation
        logic clear_step;  // write no-version at the sweep index
        logic scan_start;  // reset sweep index and search state
        logic scan_step;   // read the entry at the sweep index
        logic out_load;    // load the result register
    } bvt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [KIND_W-1:0] op;
        logic              idx_last;
        logic              out_free;
    } bvt_sts_t;

endpackage

@@ sv/bvt_in_if.sv @@
// ----------------------------------------------------------------------------
// bvt_in_if
// Request channel: operation, block index and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bvt_in_if;

    logic                         valid;
    logic                         ready;
    logic [bvt_pkg::KIND_W-1:0]   kind;
    logic [bvt_pkg::BLOCK_W-1:0]  block;
    logic [bvt_pkg::DATA_W-1:0]   value;

    modport source (output valid, kind, block, value, input ready);
    modport sink   (input valid, kind, block, value, output ready);

endinterface

@@ sv/bvt_out_if.sv @@
// ----------------------------------------------------------------------------
// bvt_out_if
// Response channel: read data and search result, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bvt_out_if;

    logic                         valid;
    logic                         ready;
    logic [bvt_pkg::DATA_W-1:0]   data_out;
    logic [bvt_pkg::BLOCK_W-1:0]  found_block;
    logic                         found;

    modport source (output valid, data_out, found_block, found, input ready);
    modport sink   (input valid, data_out, found_block, found, output ready);

endinterface

@@ sv/bvt_ctrl.sv @@
// ----------------------------------------------------------------------------
// bvt_ctrl
// Sequencer for the version table: post-reset clearing sweep, single-step
// operations and the full-table search sweep.
// ----------------------------------------------------------------------------
module bvt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bvt_pkg::bvt_sts_t sts,
    output bvt_pkg::bvt_cmd_t cmd
);
    import bvt_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.idx_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.op inside {OP_FIND_OLDEST, OP_FIND_THR})
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                    state_next = ST_RESP;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.idx_last)
                    state_next = ST_DRAIN;
            end
            // last entry compared here
            ST_DRAIN:
                state_next = ST_RESP;
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign ready_next = (state_next == ST_IDLE);
    assign in_ready   = ready_reg;

    // State and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

@@ sv/bvt_dp.sv @@
// ----------------------------------------------------------------------------
// bvt_dp
// Datapath: version counter, version memory with registered read, sweep
// index, search compare stage and the response register.
// ----------------------------------------------------------------------------
module bvt_dp #(
    parameter int NUM_BLOCKS = bvt_pkg::NUM_BLOCKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [bvt_pkg::KIND_W-1:0]   in_kind,
    input  logic [bvt_pkg::BLOCK_W-1:0]  in_block,
    input  logic [bvt_pkg::DATA_W-1:0]   in_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bvt_pkg::DATA_W-1:0]   out_data,
    output logic [bvt_pkg::BLOCK_W-1:0]  out_block,
    output logic                         out_found,
    input  bvt_pkg::bvt_cmd_t            cmd,
    output bvt_pkg::bvt_sts_t            sts
);
    import bvt_pkg::*;

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int EW = (AW > BLOCK_W) ? AW : BLOCK_W;

    // Version memory
    logic [DATA_W-1:0] mem [NUM_BLOCKS];

    // Latched request
    logic [KIND_W-1:0]  kind_reg;
    logic [BLOCK_W-1:0] block_reg;
    logic [DATA_W-1:0]  value_reg;

    logic [DATA_W-1:0]  counter_reg;
    logic [DATA_W-1:0]  rd_data_reg;
    logic [AW-1:0]      idx_reg;
    logic               cmp_en_reg;
    logic [AW-1:0]      cmp_idx_reg;
    logic [DATA_W-1:0]  best_reg;
    logic [DATA_W-1:0]  limit_reg;
    logic               thr_ok_reg;
    logic [AW-1:0]      hit_idx_reg;
    logic               hit_reg;

    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic [BLOCK_W-1:0] out_block_reg;
    logic               out_found_reg;

    logic [EW-1:0]      blk_ext;
    logic [AW-1:0]      blk_addr;
    logic               blk_in_range;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic               entry_valid;
    logic [EW-1:0]      hit_ext;
    logic [DATA_W-1:0]  res_data;
    logic [BLOCK_W-1:0] res_block;
    logic               res_found;
    logic               is_search;

    // Block index decode
    assign blk_ext      = EW'(block_reg);
    assign blk_addr     = blk_ext[AW-1:0];
    assign blk_in_range = (32'(block_reg) < 32'(NUM_BLOCKS));

    // Memory port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = NO_VERSION;
        if (cmd.clear_step)
            mem_we = 1'b1;
        else if (cmd.exec && kind_reg == OP_WR_ENTRY && blk_in_range)
        begin
            mem_we    = 1'b1;
            mem_waddr = blk_addr;
            mem_wdata = value_reg;
        end
    end

    assign mem_re    = cmd.scan_step ||
                       (cmd.exec && kind_reg == OP_RD_ENTRY && blk_in_range);
    assign mem_raddr = cmd.scan_step ? idx_reg : blk_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg  <= in_kind;
            block_reg <= in_block;
            value_reg <= in_value;
        end
    end

    // Version counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            counter_reg <= '0;
        else if (cmd.exec && kind_reg == OP_SET_CNT)
            counter_reg <= value_reg;
        else if (cmd.exec && kind_reg == OP_ADD_CNT)
            counter_reg <= counter_reg + value_reg;
    end

    // Sweep index and compare pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            cmp_en_reg <= 1'b0;
        end
        else
        begin
            cmp_en_reg <= cmd.scan_step;
            if (cmd.scan_start)
                idx_reg <= '0;
            else if (cmd.clear_step || cmd.scan_step)
                idx_reg <= sts.idx_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= idx_reg;
    end

    // Search state
    assign entry_valid = (rd_data_reg != NO_VERSION);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg    <= 1'b0;
            thr_ok_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            hit_reg    <= 1'b0;
            thr_ok_reg <= (counter_reg >= value_reg);
        end
        else if (cmp_en_reg && entry_valid)
        begin
            if (kind_reg == OP_FIND_OLDEST && rd_data_reg < best_reg)
                hit_reg <= 1'b1;
            else if (kind_reg == OP_FIND_THR && thr_ok_reg && rd_data_reg <= limit_reg)
                hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            best_reg    <= NO_VERSION;
            limit_reg   <= counter_reg - value_reg;
            hit_idx_reg <= '0;
        end
        else if (cmp_en_reg && entry_valid)
        begin
            if (kind_reg == OP_FIND_OLDEST && rd_data_reg < best_reg)
            begin
                best_reg    <= rd_data_reg;
                hit_idx_reg <= cmp_idx_reg;
            end
            else if (kind_reg == OP_FIND_THR && thr_ok_reg && rd_data_reg <= limit_reg)
                hit_idx_reg <= cmp_idx_reg;
        end
    end

    // Result composition
    assign hit_ext   = EW'(hit_idx_reg);
    assign is_search = (kind_reg == OP_FIND_OLDEST) || (kind_reg == OP_FIND_THR);

    always_comb
    begin
        res_data = '0;
        case (kind_reg)
            OP_RD_CNT:   res_data = counter_reg;
            OP_RD_ENTRY: res_data = blk_in_range ? rd_data_reg : NO_VERSION;
            default:     res_data = '0;
        endcase
        res_found = is_search && hit_reg;
        res_block = res_found ? hit_ext[BLOCK_W-1:0] : '0;
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg  <= res_data;
            out_block_reg <= res_block;
            out_found_reg <= res_found;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_block = out_block_reg;
    assign out_found = out_found_reg;

    // Status back to the sequencer
    assign sts.op       = kind_reg;
    assign sts.idx_last = (idx_reg == AW'(NUM_BLOCKS - 1));
    assign sts.out_free = !out_valid_reg || out_ready;

endmodule

@@ sv/block_version_table_unit.sv @@
// ----------------------------------------------------------------------------
// block_version_table_unit
// Flash block write-sequence tracker: global version counter plus a
// per-block version table with oldest-block and age-threshold searches.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  -------  ---  -----------------------------------
//  req      in   kind, block, value
//  rsp      out  data_out, found_block, found
//
//  After reset the table is swept to no-version, with req held not ready.
//  Counter and entry operations pass from accept through the execute state to
//  the response register; both searches add a sweep of the whole table by the
//  single read port, one entry per cycle, and a drain state for the last compare.
//  One beat is in work at a time; a new beat may be taken while the last
//  response is held by a stalled rsp, and a finished item waits for rsp to free.
// ----------------------------------------------------------------------------
module block_version_table_unit #(
    parameter int NUM_BLOCKS = bvt_pkg::NUM_BLOCKS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    bvt_in_if.sink    req,
    bvt_out_if.source rsp
);
    import bvt_pkg::*;

    bvt_cmd_t cmd;
    bvt_sts_t sts;
    logic     in_ready;

    // Sequencer
    bvt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Counter, table and response register
    bvt_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_kind   (req.kind),
        .in_block  (req.block),
        .in_value  (req.value),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp.data_out),
        .out_block (rsp.found_block),
        .out_found (rsp.found),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign req.ready = in_ready;

endmodule

@@ dv/block_version_table_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_version_table_checker
// Watches the request and response channels of the block version table,
// keeps a shadow copy of the counter and the version table, works out the
// response that each accepted request beat must produce and compares every
// accepted response beat with the oldest one still due.
// ----------------------------------------------------------------------------
module block_version_table_checker #(
    parameter int NUM_BLOCKS = bvt_pkg::NUM_BLOCKS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    bvt_in_if    req,
    bvt_out_if   rsp,
    output int   mismatches,
    output int   outstanding
);
    import bvt_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]  data_out;
        logic [BLOCK_W-1:0] found_block;
        logic               found;
    } bvt_rsp_t;

    // Shadow state of the block
    logic [DATA_W-1:0] shadow_cnt;
    logic [DATA_W-1:0] shadow_tab [NUM_BLOCKS];

    // Responses still owed by the block, oldest first
    bvt_rsp_t rsp_due [$];

    // Apply one request to the shadow state and return its response
    function automatic bvt_rsp_t apply_request(
        input logic [KIND_W-1:0]  kind,
        input logic [BLOCK_W-1:0] blk,
        input logic [DATA_W-1:0]  val
    );
        bvt_rsp_t          res;
        logic [DATA_W-1:0] best;
        logic [DATA_W-1:0] limit;
        res = '0;
        case (kind)
            OP_SET_CNT:  shadow_cnt = val;
            OP_ADD_CNT:  shadow_cnt = shadow_cnt + val;
            OP_RD_CNT:   res.data_out = shadow_cnt;
            OP_RD_ENTRY: res.data_out = (int'(blk) < NUM_BLOCKS) ? shadow_tab[blk] : NO_VERSION;
            OP_WR_ENTRY:
            begin
                if (int'(blk) < NUM_BLOCKS)
                    shadow_tab[blk] = val;
            end
            OP_FIND_OLDEST:
            begin
                // strict compare keeps the lowest index on a tie
                best = NO_VERSION;
                for (int i = 0; i < NUM_BLOCKS; i++)
                begin
                    if (shadow_tab[i] != NO_VERSION && shadow_tab[i] < best)
                    begin
                        best            = shadow_tab[i];
                        res.found_block = BLOCK_W'(i);
                        res.found       = 1'b1;
                    end
                end
            end
            OP_FIND_THR:
            begin
                // threshold above the counter finds nothing
                if (shadow_cnt >= val)
                begin
                    limit = shadow_cnt - val;
                    for (int i = 0; i < NUM_BLOCKS; i++)
                    begin
                        if (shadow_tab[i] != NO_VERSION && shadow_tab[i] <= limit)
                        begin
                            res.found_block = BLOCK_W'(i);
                            res.found       = 1'b1;
                        end
                    end
                end
            end
            default: ;  // unused kind: no change, all-zero response
        endcase
        return res;
    endfunction

    // Predict on request beats, compare on response beats
    always @(posedge clk or negedge rst_n)
    begin
        bvt_rsp_t due;
        if (!rst_n)
        begin
            shadow_cnt = '0;
            for (int i = 0; i < NUM_BLOCKS; i++)
                shadow_tab[i] = NO_VERSION;
            rsp_due.delete();
        end
        else
        begin
            if (req.valid && req.ready)
                rsp_due.push_back(apply_request(req.kind, req.block, req.value));
            if (rsp.valid && rsp.ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("response beat with no request waiting");
                    mismatches++;
                end
                else
                begin
                    due = rsp_due.pop_front();
                    if (rsp.data_out !== due.data_out)
                    begin
                        $error("data_out mismatch: expected 0x%08h, actual 0x%08h",
                               due.data_out, rsp.data_out);
                        mismatches++;
                    end
                    if (rsp.found_block !== due.found_block)
                    begin
                        $error("found_block mismatch: expected %0d, actual %0d",
                               due.found_block, rsp.found_block);
                        mismatches++;
                    end
                    if (rsp.found !== due.found)
                    begin
                        $error("found mismatch: expected %0d, actual %0d",
                               due.found, rsp.found);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = rsp_due.size();
    end

endmodule

@@ dv/block_version_table_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_version_table_unit_tb
// Drives directed and random requests into the block version table under
// four handshake phases (free flowing, idle sender, stalling receiver, both)
// and gives the verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module block_version_table_unit_tb;

    import bvt_pkg::*;

    localparam int                NUM_BLOCKS   = NUM_BLOCKS_DEF;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 3'd7;
    localparam int                RANDOM_ITEMS = 500;
    localparam int                CYCLE_LIMIT  = 3_000_000;
    localparam int                DRAIN_CYCLES = NUM_BLOCKS + 16;

    logic              clk;
    logic              rst_n;
    int                req_idle_pct;
    int                rsp_stall_pct;
    int                cycle_count;
    int                beats_sent;
    int                searches_sent;
    int                mismatches;
    int                outstanding;
    logic [DATA_W-1:0] stim_cnt;      // counter as the stimulus sees it
    logic [BLOCK_W-1:0] hot_blk [16]; // blocks that most entry traffic hits

    bvt_in_if  req_bus ();
    bvt_out_if rsp_bus ();

    block_version_table_unit #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    block_version_table_checker #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_bus),
        .rsp         (rsp_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Receiver back-pressure
    always @(negedge clk)
        rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles", cycle_count);
        $display("FAIL");
        $finish;
    end

    // Present one request beat and wait for it to be taken; valid stays high
    task automatic send_beat(
        input logic [KIND_W-1:0]  kind,
        input logic [BLOCK_W-1:0] blk,
        input logic [DATA_W-1:0]  val
    );
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.kind  <= kind;
        req_bus.block <= blk;
        req_bus.value <= val;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        @(negedge clk);
        beats_sent++;
        if (kind == OP_FIND_OLDEST || kind == OP_FIND_THR)
            searches_sent++;
        if (kind == OP_SET_CNT)
            stim_cnt = val;
        else if (kind == OP_ADD_CNT)
            stim_cnt = stim_cnt + val;
    endtask

    initial
    begin
        int work;
        req_bus.valid = 1'b0;
        req_bus.kind  = '0;
        req_bus.block = '0;
        req_bus.value = '0;
        rsp_bus.ready = 1'b0;
        rst_n         = 1'b0;
        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        stim_cnt      = '0;
        work          = 0;
        hot_blk[0]    = '0;
        hot_blk[15]   = BLOCK_W'(NUM_BLOCKS - 1);
        for (int i = 1; i < 15; i++)
            hot_blk[i] = BLOCK_W'($urandom_range(NUM_BLOCKS - 1));

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset contents, wrap, ties, erase, threshold corners
        send_beat(OP_RD_CNT,      '0,     '0);
        send_beat(OP_RD_ENTRY,    '0,     '0);
        send_beat(OP_RD_ENTRY,    '1,     '0);
        send_beat(OP_FIND_OLDEST, '0,     '0);            // empty table
        send_beat(OP_FIND_THR,    '0,     '0);            // empty table
        send_beat(OP_SET_CNT,     '0,     32'hFFFF_FFF0);
        send_beat(OP_ADD_CNT,     '0,     32'h0000_0020); // wraps to 0x10
        send_beat(OP_RD_CNT,      '0,     '0);
        send_beat(OP_WR_ENTRY,    '0,     32'd5);
        send_beat(OP_WR_ENTRY,    '1,     32'd5);
        send_beat(OP_FIND_OLDEST, '0,     '0);            // tie, lowest wins
        send_beat(OP_WR_ENTRY,    10'd512, 32'd0);
        send_beat(OP_FIND_OLDEST, '0,     '0);
        send_beat(OP_WR_ENTRY,    10'd512, NO_VERSION);   // erase entry
        send_beat(OP_RD_ENTRY,    10'd512, '0);
        send_beat(OP_FIND_OLDEST, '0,     '0);
        send_beat(OP_FIND_THR,    '0,     32'h0000_0011); // above counter
        send_beat(OP_FIND_THR,    '0,     32'h0000_0010); // limit zero
        send_beat(OP_FIND_THR,    '0,     32'h0000_000B); // limit five
        send_beat(KIND_UNUSED,    '1,     '1);
        send_beat(OP_WR_ENTRY,    10'd1,  32'hFFFF_FFFE);
        send_beat(OP_SET_CNT,     '0,     '1);
        send_beat(OP_FIND_THR,    '0,     '0);            // widest limit
        send_beat(OP_RD_ENTRY,    10'd1,  '0);
        send_beat(OP_ADD_CNT,     '0,     '1);

        // Random traffic, one handshake phase per quarter
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    req_idle_pct  = 0;
                    rsp_stall_pct = 0;
                end
                1:
                begin
                    req_idle_pct  = 51;
                    rsp_stall_pct = 0;
                end
                2:
                begin
                    req_idle_pct  = 0;
                    rsp_stall_pct = 51;
                end
                default:
                begin
                    req_idle_pct  = 36;
                    rsp_stall_pct = 36;
                end
            endcase
            while (work < (ph + 1) * RANDOM_ITEMS / 4)
            begin : rand_item
                int                 pick;
                int                 sub;
                logic [BLOCK_W-1:0] blk;
                logic [DATA_W-1:0]  val;
                pick = $urandom_range(99);
                sub  = $urandom_range(99);
                blk  = ($urandom_range(1) != 0) ? hot_blk[4'($urandom_range(15))]
                                                : BLOCK_W'($urandom_range(NUM_BLOCKS - 1));
                if (pick < 28)
                begin
                    // writes mostly stamp the current counter or one a little below it, as real use does
                    if (sub < 40)
                        val = stim_cnt;
                    else if (sub < 65)
                        val = stim_cnt - DATA_W'($urandom_range(64));
                    else if (sub < 75)
                        val = NO_VERSION;
                    else if (sub < 85)
                        val = $urandom;
                    else
                        val = DATA_W'($urandom_range(15));
                    send_beat(OP_WR_ENTRY, blk, val);
                end
                else if (pick < 42)
                    send_beat(OP_RD_ENTRY, blk, $urandom);
                else if (pick < 48)
                begin
                    if (sub < 20)
                        val = '0;
                    else if (sub < 40)
                        val = NO_VERSION - DATA_W'($urandom_range(8));
                    else
                        val = $urandom;
                    send_beat(OP_SET_CNT, blk, val);
                end
                else if (pick < 58)
                begin
                    val = (sub < 70) ? DATA_W'($urandom_range(1, 4)) : DATA_W'($urandom);
                    send_beat(OP_ADD_CNT, blk, val);
                end
                else if (pick < 65)
                    send_beat(OP_RD_CNT, blk, $urandom);
                else if (pick < 76)
                    send_beat(OP_FIND_OLDEST, blk, $urandom);
                else if (pick < 90)
                begin
                    if (sub < 30)
                        val = $urandom;
                    else if (sub < 70)
                        val = DATA_W'($urandom_range(64));
                    else if (sub < 85)
                        val = stim_cnt;
                    else
                        val = stim_cnt + 1'b1;
                    send_beat(OP_FIND_THR, blk, val);
                end
                else
                begin
                    // noise: unused kind, not counted as work
                    send_beat(KIND_UNUSED, blk, $urandom);
                    work--;
                end
                work++;
            end
        end
        req_bus.valid <= 1'b0;

        // Drain, then watch for stray responses
        while (outstanding != 0)
            @(negedge clk);
        rsp_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d request beats, %0d of them table searches, over four handshake phases.",
                 beats_sent, searches_sent);
        $display("Checker reported %0d mismatches after %0d cycles.", mismatches, cycle_count);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ block_version_table_unit.f @@
sv/bvt_pkg.sv
sv/bvt_in_if.sv
sv/bvt_out_if.sv
sv/bvt_ctrl.sv
sv/bvt_dp.sv
sv/block_version_table_unit.sv
dv/block_version_table_checker.sv
dv/block_version_table_unit_tb.sv
